// ===== hw/rtl/kml_pkg.sv =====
// ---------------------------------------------------------------------------
// kml_pkg
// Shared widths, codes and the command/status bundles between the k-means
// controller and its datapath.
// ---------------------------------------------------------------------------
package kml_pkg;

  localparam int COORD_W    = 16;
  localparam int DIST_W     = 35;
  localparam int COST_W     = 52;
  localparam int COST_OUT_W = 51;
  localparam int IDX_W      = 3;
  localparam int ACT_W      = 2;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int STAT_W     = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_POINT  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } kml_action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_LIMIT = 2'd2
  } kml_status_e;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_MEAN   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;     // input item taken this cycle
    logic             dif;        // latch point minus centroid
    logic             sq;         // square the difference
    logic             acc;        // add square into the distance sum
    logic             cmp;        // compare distance against the best so far
    logic             use_best;   // sum store addressed by the winning cluster
    logic             sum_wr;     // write back one updated cluster sum
    logic             commit;     // bump count, cost and point total
    logic             out_assign; // load an assignment result
    logic             out_reject; // load a point-limit result
    logic             fin_lat;    // latch old centroid and start the divide
    logic             fin_out;    // load a mean result and write it back
    logic             fin_last;   // final mean of the finish run
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } kml_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             pt_done;
    logic             limit;
    logic             out_free;
    logic             div_done;
    logic             div_busy;
    logic             cnt_zero;
    logic [CFG_W-1:0] k;
    logic [CFG_W-1:0] dims;
  } kml_sts_t;

endpackage

// ===== hw/rtl/kml_ram.sv =====
// ---------------------------------------------------------------------------
// kml_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kml_div.sv =====
// ---------------------------------------------------------------------------
// kml_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ---------------------------------------------------------------------------
module kml_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  mag_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    rem_q;
  logic [STEP_W-1:0] cnt_q;
  logic              neg_q, busy_q, done_q;
  logic [DEN_W:0]    rem_sh, rem_nx;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend magnitude register also collects the quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      neg_q <= num_i[NUM_W-1];
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[NUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ===== hw/rtl/kml_datapath.sv =====
// ---------------------------------------------------------------------------
// kml_datapath
// Centroid and sum stores, point buffer, distance unit, counters, cost,
// configuration registers and the output register.
// ---------------------------------------------------------------------------
module kml_datapath #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_DIMS     = 8,
  parameter int MAX_POINTS   = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kml_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kml_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [kml_pkg::ACT_W-1:0]           action_i,
  input  logic [kml_pkg::IDX_W-1:0]           cluster_index_i,
  input  logic [kml_pkg::IDX_W-1:0]           coord_index_i,
  input  logic signed [kml_pkg::COORD_W-1:0]  value_i,
  input  logic                                out_ready_i,
  input  kml_pkg::kml_cmd_t                   cmd_i,
  output kml_pkg::kml_sts_t                   sts_o,
  output logic                                out_valid_o,
  output logic                                kind_o,
  output logic [kml_pkg::IDX_W-1:0]           cluster_o,
  output logic [kml_pkg::IDX_W-1:0]           coord_index_res_o,
  output logic signed [kml_pkg::COORD_W-1:0]  mean_value_o,
  output logic [kml_pkg::DIST_W-1:0]          distance_o,
  output logic [kml_pkg::COST_OUT_W-1:0]      total_cost_o,
  output logic [kml_pkg::STAT_W-1:0]          status_o,
  output logic                                last_o
);
  import kml_pkg::*;

  localparam int SLOTS  = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW     = $clog2(SLOTS);
  localparam int CI_W   = $clog2(MAX_CLUSTERS);
  localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;

  function automatic logic [AW-1:0] slot_addr(logic [IDX_W-1:0] c, logic [IDX_W-1:0] d);
    slot_addr = AW'(int'(c) * MAX_DIMS + int'(d));
  endfunction

  // Configuration.
  logic [CFG_W-1:0] cfg_k_q, cfg_d_q, k_use, d_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q <= CFG_W'(2);
      cfg_d_q <= CFG_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_CLUSTERS: cfg_k_q <= cfg_wdata_i;
        REG_NUM_DIMS:     cfg_d_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_use = cfg_k_q;
    if (cfg_k_q == '0) k_use = CFG_W'(1);
    else if (cfg_k_q > CFG_W'(MAX_CLUSTERS)) k_use = CFG_W'(MAX_CLUSTERS);
    d_use = cfg_d_q;
    if (cfg_d_q == '0) d_use = CFG_W'(1);
    else if (cfg_d_q > CFG_W'(MAX_DIMS)) d_use = CFG_W'(MAX_DIMS);
  end

  // Stores and state.
  logic signed [COORD_W-1:0] pb_q [MAX_DIMS];
  logic [CNT_W-1:0]          cnt_q [MAX_CLUSTERS];
  logic [CNT_W-1:0]          pts_q;
  logic [COST_W-1:0]         cost_q;
  logic [SLOTS-1:0]          cent_vld_q, sum_vld_q;
  logic [AW-1:0]             cent_ra_q, sum_ra_q;
  logic signed [DIFF_W-1:0]  dif_q;
  logic [SQ_W-1:0]           sq_q;
  logic [DIST_W-1:0]         acc_q, best_q;
  logic [IDX_W-1:0]          best_c_q;
  logic signed [COORD_W-1:0] old_q;

  logic                      in_load_ok, in_pt_ok;
  logic                      cent_we, sum_we;
  logic [AW-1:0]             cent_wa, cent_ra, sum_ra;
  logic [COORD_W-1:0]        cent_wd, cent_rd_raw;
  logic [SUM_W-1:0]          sum_wd, sum_rd_raw;
  logic signed [COORD_W-1:0] cent_rd, pb_d, mean_sel;
  logic signed [SUM_W-1:0]   sum_rd;
  logic signed [SQ_W-1:0]    prod;
  logic                      cnt_zero, div_done, div_busy;
  logic signed [SUM_W-1:0]   div_quo;
  logic [CI_W-1:0]           c_sel;

  assign in_load_ok = cmd_i.accept && (action_i == ACT_LOAD) &&
                      (int'(cluster_index_i) < MAX_CLUSTERS) &&
                      (int'(coord_index_i) < MAX_DIMS);
  assign in_pt_ok   = (action_i == ACT_POINT) && (int'(coord_index_i) < MAX_DIMS);

  assign c_sel    = cmd_i.c[CI_W-1:0];
  assign pb_d     = pb_q[cmd_i.d[DI_W-1:0]];
  assign cnt_zero = (cnt_q[c_sel] == '0);

  // Store reads: entries never written read as zero.
  assign cent_ra = slot_addr(cmd_i.c, cmd_i.d);
  assign sum_ra  = slot_addr(cmd_i.use_best ? best_c_q : cmd_i.c, cmd_i.d);
  assign cent_rd = cent_vld_q[cent_ra_q] ? $signed(cent_rd_raw) : '0;
  assign sum_rd  = sum_vld_q[sum_ra_q] ? $signed(sum_rd_raw) : '0;

  assign cent_we = in_load_ok || cmd_i.fin_out;
  assign cent_wa = in_load_ok ? slot_addr(cluster_index_i, coord_index_i) : cent_ra;
  assign cent_wd = in_load_ok ? value_i : mean_sel;

  assign sum_we = cmd_i.sum_wr;
  assign sum_wd = sum_rd + SUM_W'(pb_d);

  assign mean_sel = cnt_zero ? old_q : div_quo[COORD_W-1:0];
  assign prod     = dif_q * dif_q;

  kml_ram #(.WIDTH(COORD_W), .DEPTH(SLOTS)) u_cent_ram (
    .clk_i   (clk_i),
    .we_i    (cent_we),
    .waddr_i (cent_wa),
    .wdata_i (cent_wd),
    .raddr_i (cent_ra),
    .rdata_o (cent_rd_raw)
  );

  kml_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_ra),
    .wdata_i (sum_wd),
    .raddr_i (sum_ra),
    .rdata_o (sum_rd_raw)
  );

  kml_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fin_lat && !cnt_zero),
    .num_i   (sum_rd),
    .den_i   (cnt_q[c_sel]),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Control state: valid flags, counts, cost, point total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_vld_q <= '0;
      sum_vld_q  <= '0;
      pts_q      <= '0;
      cost_q     <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
    end else begin
      if (cent_we) cent_vld_q[cent_wa] <= 1'b1;
      if (sum_we) sum_vld_q[sum_ra] <= 1'b1;
      if (cmd_i.commit) begin
        cnt_q[best_c_q[CI_W-1:0]] <= cnt_q[best_c_q[CI_W-1:0]] + 1'b1;
        cost_q <= cost_q + COST_W'(best_q);
        pts_q  <= pts_q + 1'b1;
      end
      if (cmd_i.fin_out && cmd_i.fin_last) begin
        sum_vld_q <= '0;
        pts_q     <= '0;
        cost_q    <= '0;
        for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
      end
    end
  end

  // Payload registers of the distance search.
  always_ff @(posedge clk_i) begin
    cent_ra_q <= cent_ra;
    sum_ra_q  <= sum_ra;
    if (cmd_i.accept && in_pt_ok) pb_q[coord_index_i[DI_W-1:0]] <= value_i;
    if (cmd_i.dif) dif_q <= DIFF_W'(pb_d) - DIFF_W'(cent_rd);
    if (cmd_i.sq) sq_q <= SQ_W'(prod);
    if (cmd_i.accept || cmd_i.cmp) acc_q <= '0;
    else if (cmd_i.acc) acc_q <= acc_q + DIST_W'(sq_q);
    if (cmd_i.cmp && (cmd_i.c == '0 || acc_q < best_q)) begin
      best_q   <= acc_q;
      best_c_q <= cmd_i.c;
    end
    if (cmd_i.fin_lat) old_q <= cent_rd;
  end

  // Output register.
  logic                      out_valid_q;
  logic                      kind_q, last_q;
  logic [IDX_W-1:0]          cluster_q, cidx_q;
  logic signed [COORD_W-1:0] mean_q;
  logic [DIST_W-1:0]         dist_q;
  logic [COST_OUT_W-1:0]     cost_out_q;
  logic [STAT_W-1:0]         stat_q;
  logic                      out_load;

  assign out_load = cmd_i.out_assign || cmd_i.out_reject || cmd_i.fin_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q     <= cmd_i.fin_out ? KIND_MEAN : KIND_ASSIGN;
      cluster_q  <= cmd_i.fin_out ? cmd_i.c : (cmd_i.out_assign ? best_c_q : '0);
      cidx_q     <= cmd_i.fin_out ? cmd_i.d : '0;
      mean_q     <= cmd_i.fin_out ? mean_sel : '0;
      dist_q     <= cmd_i.out_assign ? best_q : '0;
      cost_out_q <= cost_q[COST_OUT_W-1:0];
      last_q     <= cmd_i.fin_out && cmd_i.fin_last;
      if (cmd_i.out_reject) stat_q <= STAT_LIMIT;
      else if (cmd_i.fin_out && cnt_zero) stat_q <= STAT_EMPTY;
      else stat_q <= STAT_OK;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign cluster_o         = cluster_q;
  assign coord_index_res_o = cidx_q;
  assign mean_value_o      = mean_q;
  assign distance_o        = dist_q;
  assign total_cost_o      = cost_out_q;
  assign status_o          = stat_q;
  assign last_o            = last_q;

  always_comb begin
    sts_o          = '0;
    sts_o.pt_done  = in_pt_ok && ({1'b0, coord_index_i} == d_use - CFG_W'(1));
    sts_o.limit    = pts_q >= CNT_W'(MAX_POINTS);
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.div_done = div_done;
    sts_o.div_busy = div_busy;
    sts_o.cnt_zero = cnt_zero;
    sts_o.k        = k_use;
    sts_o.dims     = d_use;
  end

endmodule

// ===== hw/rtl/kml_ctrl.sv =====
// ---------------------------------------------------------------------------
// kml_ctrl
// Sequencer for item intake, the nearest-centroid search, the sum update
// and the finish run.
// ---------------------------------------------------------------------------
module kml_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kml_pkg::ACT_W-1:0] action_i,
  input  kml_pkg::kml_sts_t         sts_i,
  output kml_pkg::kml_cmd_t         cmd_o
);
  import kml_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_D_RD  = 14'b00000000000010,
    S_D_DIF = 14'b00000000000100,
    S_D_SQ  = 14'b00000000001000,
    S_D_ACC = 14'b00000000010000,
    S_D_CMP = 14'b00000000100000,
    S_S_RD  = 14'b00000001000000,
    S_S_WR  = 14'b00000010000000,
    S_A_OUT = 14'b00000100000000,
    S_R_OUT = 14'b00001000000000,
    S_F_RD  = 14'b00010000000000,
    S_F_LAT = 14'b00100000000000,
    S_F_DIV = 14'b01000000000000,
    S_F_OUT = 14'b10000000000000
  } kml_state_e;

  kml_state_e       state_q, state_d;
  logic [IDX_W-1:0] c_q, c_d, d_q, d_d;
  logic             c_last, d_last;

  assign c_last = ({1'b0, c_q} == sts_i.k - CFG_W'(1));
  assign d_last = ({1'b0, d_q} == sts_i.dims - CFG_W'(1));

  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    d_d        = d_q;
    cmd_o      = '0;
    cmd_o.c    = c_q;
    cmd_o.d    = d_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          c_d = '0;
          d_d = '0;
          if (action_i == ACT_POINT && sts_i.pt_done) begin
            state_d = sts_i.limit ? S_R_OUT : S_D_RD;
          end else if (action_i == ACT_FINISH) begin
            state_d = S_F_RD;
          end
        end
      end
      S_D_RD: state_d = S_D_DIF;
      S_D_DIF: begin
        cmd_o.dif = 1'b1;
        state_d   = S_D_SQ;
      end
      S_D_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_D_ACC;
      end
      S_D_ACC: begin
        cmd_o.acc = 1'b1;
        if (d_last) begin
          state_d = S_D_CMP;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = S_D_RD;
        end
      end
      S_D_CMP: begin
        cmd_o.cmp = 1'b1;
        d_d       = '0;
        if (c_last) begin
          state_d = S_S_RD;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_D_RD;
        end
      end
      S_S_RD: begin
        cmd_o.use_best = 1'b1;
        state_d        = S_S_WR;
      end
      S_S_WR: begin
        cmd_o.use_best = 1'b1;
        cmd_o.sum_wr   = 1'b1;
        if (d_last) begin
          cmd_o.commit = 1'b1;
          state_d      = S_A_OUT;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = S_S_RD;
        end
      end
      S_A_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_assign = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_R_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_reject = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_F_RD: state_d = S_F_LAT;
      S_F_LAT: begin
        cmd_o.fin_lat = 1'b1;
        state_d       = sts_i.cnt_zero ? S_F_OUT : S_F_DIV;
      end
      S_F_DIV: begin
        if (sts_i.div_done) state_d = S_F_OUT;
      end
      S_F_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.fin_out  = 1'b1;
          cmd_o.fin_last = c_last && d_last;
          if (d_last) begin
            d_d     = '0;
            c_d     = c_q + 1'b1;
            state_d = c_last ? S_IDLE : S_F_RD;
          end else begin
            d_d     = d_q + 1'b1;
            state_d = S_F_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      d_q     <= d_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_fin_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_out && cmd_o.fin_last |=> state_q == S_IDLE)
    else $error("finish run did not return to idle");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_F_DIV)
    else $error("divider finished outside the divide wait");
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.div_busy)
    else $error("divider busy while taking items");
  a_out_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.out_assign, cmd_o.out_reject, cmd_o.fin_out}))
    else $error("two results loaded at once");
`endif

endmodule

// ===== hw/rtl/kmeans_lloyd_step_top.sv =====
// Loads, and coordinates that do not complete a point, leave the controller idle.
// Completed point: search, sum update and result load come before the next accept
// (one shared multiplier, one centroid-store read per coordinate); the assignment
// item is last. Finish: per mean a store read, a latch and the bit-serial divide
// (skipped for an empty cluster) come before its result; k*D items.
// Reset clears control state; centroids, sums and counts read as zero, no pass.
// ---------------------------------------------------------------------------
// kmeans_lloyd_step_top
// One Lloyd k-means iteration in Q8.8 fixed point: centroid load, point
// assignment with running sums and cost, and a finish run reporting means.
// ---------------------------------------------------------------------------
module kmeans_lloyd_step_top #(
  parameter int MAX_CLUSTERS = 8,
  parameter int MAX_DIMS     = 8,
  parameter int MAX_POINTS   = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kml_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [kml_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [kml_pkg::ACT_W-1:0]           action_i,
  input  logic [kml_pkg::IDX_W-1:0]           cluster_index_i,
  input  logic [kml_pkg::IDX_W-1:0]           coord_index_i,
  input  logic signed [kml_pkg::COORD_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic [kml_pkg::IDX_W-1:0]           cluster_o,
  output logic [kml_pkg::IDX_W-1:0]           coord_index_res_o,
  output logic signed [kml_pkg::COORD_W-1:0]  mean_value_o,
  output logic [kml_pkg::DIST_W-1:0]          distance_o,
  output logic [kml_pkg::COST_OUT_W-1:0]      total_cost_o,
  output logic [kml_pkg::STAT_W-1:0]          status_o,
  output logic                                last_o
);
  import kml_pkg::*;

  kml_cmd_t cmd;
  kml_sts_t sts;

  kml_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kml_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (action_i),
    .cluster_index_i   (cluster_index_i),
    .coord_index_i     (coord_index_i),
    .value_i           (value_i),
    .out_ready_i       (out_ready_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .cluster_o         (cluster_o),
    .coord_index_res_o (coord_index_res_o),
    .mean_value_o      (mean_value_o),
    .distance_o        (distance_o),
    .total_cost_o      (total_cost_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

endmodule

// ===== sim/kmeans_lloyd_step_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmeans_lloyd_step_top_tb
// Drives centroid loads, point streams and finish runs into the k-means block
// and checks every result against an in-bench model of the iteration.
// ---------------------------------------------------------------------------
module kmeans_lloyd_step_top_tb;
  import kml_pkg::*;

  localparam int NCL = 8;
  localparam int NDM = 8;
  localparam int NPTS = 65536;
  localparam int SETTLE = 3000;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         cluster;
    logic [IDX_W-1:0]         coord;
    logic signed [COORD_W-1:0] mean;
    logic [DIST_W-1:0]        distance;
    logic [COST_OUT_W-1:0]    cost;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } kml_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] action = ACT_NONE;
  logic [IDX_W-1:0] cl_idx = '0;
  logic [IDX_W-1:0] co_idx = '0;
  logic signed [COORD_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  kml_res_t got;

  kmeans_lloyd_step_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .cluster_index_i(cl_idx), .coord_index_i(co_idx),
    .value_i(value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(got.kind), .cluster_o(got.cluster), .coord_index_res_o(got.coord),
    .mean_value_o(got.mean), .distance_o(got.distance), .total_cost_o(got.cost),
    .status_o(got.status), .last_o(got.last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state of the iteration.
  longint centroid[NCL*NDM];
  longint pt[NDM];
  longint sums[NCL*NDM];
  longint unsigned counts[NCL];
  longint unsigned cost_acc;
  longint unsigned n_points;
  logic [CFG_W-1:0] k_reg = 4'd2;
  logic [CFG_W-1:0] d_reg = 4'd2;
  kml_res_t results_due[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic int clamp_cfg(logic [CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic kml_res_t mk(logic kd, int c, int d, longint m, longint unsigned ds,
                                  logic [STAT_W-1:0] st, logic lst);
    kml_res_t r;
    r.kind = kd; r.cluster = c[2:0]; r.coord = d[2:0]; r.mean = m[15:0];
    r.distance = ds[34:0];
    r.cost = cost_acc[50:0]; r.status = st; r.last = lst;
    return r;
  endfunction

  task automatic predict_lloyd(logic [ACT_W-1:0] a, int c, int d, logic signed [15:0] v);
    int k, nd, best;
    longint unsigned bd, dd;
    longint df, m;
    k = clamp_cfg(k_reg, NCL);
    nd = clamp_cfg(d_reg, NDM);
    if (a == ACT_LOAD) begin
      centroid[c*NDM+d] = longint'(v);
    end else if (a == ACT_POINT) begin
      pt[d] = longint'(v);
      if (d != nd - 1) return;
      if (n_points >= NPTS) begin
        results_due.push_back(mk(KIND_ASSIGN, 0, 0, 0, 0, STAT_LIMIT, 1'b0));
        return;
      end
      best = 0;
      bd = 0;
      for (int ci = 0; ci < k; ci++) begin
        dd = 0;
        for (int j = 0; j < nd; j++) begin
          df = pt[j] - centroid[ci*NDM+j];
          dd += df * df;
        end
        if (ci == 0 || dd < bd) begin
          bd = dd;
          best = ci;
        end
      end
      counts[best]++;
      for (int j = 0; j < nd; j++) sums[best*NDM+j] += pt[j];
      cost_acc = (cost_acc + bd) & ((64'd1 << 52) - 1);
      n_points++;
      results_due.push_back(mk(KIND_ASSIGN, best, 0, 0, bd, STAT_OK, 1'b0));
    end else if (a == ACT_FINISH) begin
      for (int ci = 0; ci < k; ci++)
        for (int j = 0; j < nd; j++) begin
          if (counts[ci] > 0) begin
            m = sums[ci*NDM+j] / longint'(counts[ci]);
            results_due.push_back(mk(KIND_MEAN, ci, j, m, 0, STAT_OK,
                                     ci == k-1 && j == nd-1));
          end else begin
            m = centroid[ci*NDM+j];
            results_due.push_back(mk(KIND_MEAN, ci, j, m, 0, STAT_EMPTY,
                                     ci == k-1 && j == nd-1));
          end
          centroid[ci*NDM+j] = m;
        end
      foreach (sums[i]) sums[i] = 0;
      foreach (counts[i]) counts[i] = 0;
      cost_acc = 0;
      n_points = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    errors++;
    $display("%0t mismatch %s: expected %0h got %0h", $time, what, exp_v, got_v);
  endtask

  // Result checker with random stalls.
  initial begin
    kml_res_t e;
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = results_due.pop_front();
          if (got.kind !== e.kind)
            report_mismatch("kind", 64'(e.kind), 64'(got.kind));
          if (got.cluster !== e.cluster)
            report_mismatch("cluster", 64'(e.cluster), 64'(got.cluster));
          if (got.coord !== e.coord)
            report_mismatch("coord", 64'(e.coord), 64'(got.coord));
          if (got.mean !== e.mean)
            report_mismatch("mean", 64'(e.mean), 64'(got.mean));
          if (got.distance !== e.distance)
            report_mismatch("distance", 64'(e.distance), 64'(got.distance));
          if (got.cost !== e.cost)
            report_mismatch("cost", 64'(e.cost), 64'(got.cost));
          if (got.status !== e.status)
            report_mismatch("status", 64'(e.status), 64'(got.status));
          if (got.last !== e.last)
            report_mismatch("last", 64'(e.last), 64'(got.last));
        end
      end
    end
  end

  // Sends one item; called right after a falling edge. Valid stays high after
  // the accept until the next item, an idle gap or a drain takes it down.
  task automatic send_item(logic [ACT_W-1:0] a, int c, int d, logic signed [15:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= a; cl_idx <= IDX_W'(c); co_idx <= IDX_W'(d); value <= v;
    do @(posedge clk); while (!in_ready);
    predict_lloyd(a, c, d, v);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_CLUSTERS) k_reg = v; else d_reg = v;
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 65535));
      default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
    endcase
  endfunction

  task automatic send_point(int nd);
    for (int j = 0; j < nd; j++) send_item(ACT_POINT, 0, j, rand_coord());
  endtask

  task automatic test_directed();
    // Reset dims = 2, k = 2; extremes and a tie at zero distance.
    send_item(ACT_POINT, 0, 0, 16'sh7fff);
    send_item(ACT_POINT, 0, 1, 16'sh8000);
    send_item(ACT_POINT, 0, 0, 0);
    send_item(ACT_POINT, 0, 1, 0);
    send_item(ACT_NONE, 5, 5, 16'sh1234);
    send_item(ACT_LOAD, 1, 0, 16'sh0100);
    send_item(ACT_LOAD, 7, 7, 16'sh8000);
    send_item(ACT_POINT, 0, 7, 16'sh0055);
    send_item(ACT_POINT, 0, 0, 16'sh0100);
    send_item(ACT_POINT, 0, 1, 16'sh0000);
    send_item(ACT_FINISH, 0, 0, 0);
    drain_results();
    // Empty clusters everywhere.
    send_item(ACT_FINISH, 3, 3, 0);
    drain_results();
  endtask

  task automatic test_config_extremes();
    logic [CFG_W-1:0] kv[4] = '{4'd0, 4'd15, 4'd8, 4'd1};
    logic [CFG_W-1:0] dv[4] = '{4'd15, 4'd0, 4'd1, 4'd8};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_NUM_CLUSTERS, kv[p]);
      write_reg(REG_NUM_DIMS, dv[p]);
      for (int n = 0; n < 3; n++) send_point(clamp_cfg(dv[p], NDM));
      send_item(ACT_FINISH, 0, 0, 0);
      drain_results();
    end
  endtask

  task automatic test_random_iterations();
    int nd, k, npts, sent;
    sent = 0;
    while (sent < 150) begin
      k = $urandom_range(1, 8);
      nd = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) nd = 8;
      write_reg(REG_NUM_CLUSTERS, CFG_W'(k));
      write_reg(REG_NUM_DIMS, CFG_W'(nd));
      for (int c = 0; c < k; c++)
        for (int j = 0; j < nd; j++)
          if ($urandom_range(0, 3) != 0) begin
            send_item(ACT_LOAD, c, j, rand_coord());
            sent++;
          end
      npts = $urandom_range(1, 8);
      for (int n = 0; n < npts; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 7),
                    $urandom_range(0, 7), rand_coord());
          sent++;
        end
        send_point(nd);
        sent += nd;
      end
      if (sent > 120) quiet = 1'b1;
      send_item(ACT_FINISH, 0, 0, 0);
      sent++;
      drain_results();
    end
  endtask

  initial begin
    foreach (centroid[i]) begin
      centroid[i] = 0; sums[i] = 0;
    end
    foreach (pt[i]) pt[i] = 0;
    foreach (counts[i]) counts[i] = 0;
    cost_acc = 0;
    n_points = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_random_iterations();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
